@@ src/swtm_pkg.sv @@
`timescale 1ns / 1ps
package swtm_pkg;

   localparam int POSE_W     = 9;
   localparam int TIDX_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int COUNT_MAX  = 31;
   localparam int GROUP_SIZE = 8;
   localparam int GROUP_W    = 4;

   localparam logic signed [POSE_W-1:0] NO_POSE = -9'sd1;

   typedef enum logic {
      REQ_POSE     = 1'b0,
      REQ_TEMPLATE = 1'b1
   } req_kind_type;

   // per-cell control for one accepted request
   typedef struct packed {
      logic load;
      logic shift;
      logic tmpl_wr;
   } cell_ctl_type;

endpackage

@@ src/sliding_window_template_match.sv @@
`timescale 1ns / 1ps
// Sliding-window template matcher. Takes one request per cycle: a pose
// observation (shifted into the window unless it is -1) or a template write.
// Every request returns one response with the accepted flag and the number of
// window slots, oldest first, that equal the template, saturated at 31.
// The row of window cells updates and compares, then a two-stage tally
// adds the match bits in groups of eight. Throughput is one request per
// cycle; while the response is stalled the pipeline still takes up to two
// more requests before it raises req_stall.
module sliding_window_template_match import swtm_pkg::*; #(
   parameter int WINDOW_LEN = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_type,
   input  logic signed [POSE_W-1:0] req_pose,
   input  logic [TIDX_W-1:0]        req_template_index,
   input  logic signed [POSE_W-1:0] req_template_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_accepted,
   output logic [COUNT_W-1:0]       rsp_match_count
);

   logic                     req_acc, shift_en, tmpl_en, s1_take;
   logic                     s1_valid_ff, s1_accepted_ff;
   logic [WINDOW_LEN-1:0]    match;
   logic signed [POSE_W-1:0] win  [WINDOW_LEN];
   logic signed [POSE_W-1:0] tmpl [WINDOW_LEN];
   cell_ctl_type             ctl  [WINDOW_LEN];

   assign req_stall = s1_valid_ff && !s1_take;
   assign req_acc   = req_valid && !req_stall;
   assign shift_en  = (req_type == REQ_POSE) && (req_pose != NO_POSE);
   assign tmpl_en   = (req_type == REQ_TEMPLATE);

   genvar i;
   generate
      for (i = 0; i < WINDOW_LEN; i++) begin : g_cell
         logic signed [POSE_W-1:0] feed;
         if (i == WINDOW_LEN - 1) begin : g_newest
            assign feed = req_pose;
         end else begin : g_inner
            assign feed = win[i+1];
         end

         assign ctl[i].load    = req_acc;
         assign ctl[i].shift   = req_acc && shift_en;
         assign ctl[i].tmpl_wr = req_acc && tmpl_en && (32'(req_template_index) == i);

         swtm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl[i]),
            .shift_in   (feed),
            .tmpl_value (req_template_value),
            .win_out    (win[i]),
            .tmpl_out   (tmpl[i]),
            .match      (match[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_take) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_accepted_ff <= shift_en;
      end
   end

   swtm_tally #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_tally (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s1_valid_ff),
      .in_accepted     (s1_accepted_ff),
      .in_match        (match),
      .in_take         (s1_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_match_count (rsp_match_count)
   );

   a_shift_newest: assert property (@(posedge clock) disable iff (reset)
      req_acc && shift_en |=> win[WINDOW_LEN-1] == $past(req_pose))
      else $error("newest window slot does not hold the shifted pose");

   a_hold_window: assert property (@(posedge clock) disable iff (reset)
      req_acc && !shift_en |=> $stable(win[WINDOW_LEN-1]) && $stable(win[0]))
      else $error("window moved without a pose shift");

   a_oldest_tmpl: assert property (@(posedge clock) disable iff (reset)
      req_acc && tmpl_en && req_template_index == '0
      |=> tmpl[0] == $past(req_template_value))
      else $error("template write to the oldest slot lost");

   a_stage_load: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_valid_ff)
      else $error("accepted request missing from first stage");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_match_count) <= WINDOW_LEN)
      else $error("match count exceeds window length");

endmodule

@@ src/swtm_cell.sv @@
`timescale 1ns / 1ps
module swtm_cell import swtm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctl_type             ctl,
   input  logic signed [POSE_W-1:0] shift_in,
   input  logic signed [POSE_W-1:0] tmpl_value,
   output logic signed [POSE_W-1:0] win_out,
   output logic signed [POSE_W-1:0] tmpl_out,
   output logic                     match
);

   logic signed [POSE_W-1:0] window_ff, window_in;
   logic signed [POSE_W-1:0] tmpl_ff, tmpl_in;
   logic                     match_ff;

   always_comb begin
      window_in = ctl.shift ? shift_in : window_ff;
      tmpl_in   = ctl.tmpl_wr ? tmpl_value : tmpl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= NO_POSE;
         tmpl_ff   <= NO_POSE;
      end else if (ctl.load) begin
         window_ff <= window_in;
         tmpl_ff   <= tmpl_in;
      end
   end

   // compare against the updated contents
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         match_ff <= (window_in == tmpl_in);
      end
   end

   assign win_out  = window_ff;
   assign tmpl_out = tmpl_ff;
   assign match    = match_ff;

endmodule

@@ src/swtm_tally.sv @@
`timescale 1ns / 1ps
module swtm_tally import swtm_pkg::*; #(
   parameter int WINDOW_LEN = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  in_accepted,
   input  logic [WINDOW_LEN-1:0] in_match,
   output logic                  in_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_accepted,
   output logic [COUNT_W-1:0]    rsp_match_count
);

   localparam int NGROUP  = (WINDOW_LEN + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_LEN = NGROUP * GROUP_SIZE;
   localparam int SUM_RAW = $clog2(PAD_LEN + 1);
   localparam int SUM_W   = (SUM_RAW > COUNT_W) ? SUM_RAW : COUNT_W;

   logic [PAD_LEN-1:0] padded;
   logic [GROUP_W-1:0] group_in [NGROUP];
   logic [GROUP_W-1:0] group_ff [NGROUP];
   logic               s2_valid_ff, s2_accepted_ff, s2_adv;
   logic [SUM_W-1:0]   sum;
   logic               rsp_valid_ff, rsp_accepted_ff;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign s2_adv  = !rsp_valid_ff || !rsp_stall;
   assign in_take = !s2_valid_ff || s2_adv;

   always_comb begin
      padded = '0;
      padded[WINDOW_LEN-1:0] = in_match;
      for (int g = 0; g < NGROUP; g++) begin
         group_in[g] = '0;
         for (int b = 0; b < GROUP_SIZE; b++) begin
            group_in[g] = group_in[g] + GROUP_W'(padded[g*GROUP_SIZE + b]);
         end
      end
   end

   always_comb begin
      sum = '0;
      for (int g = 0; g < NGROUP; g++) begin
         sum = sum + SUM_W'(group_ff[g]);
      end
      count_in = (sum > SUM_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : COUNT_W'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_take) begin
            s2_valid_ff <= in_valid;
         end
         if (s2_adv) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && in_valid) begin
         s2_accepted_ff <= in_accepted;
         for (int g = 0; g < NGROUP; g++) begin
            group_ff[g] <= group_in[g];
         end
      end
      if (s2_adv && s2_valid_ff) begin
         rsp_accepted_ff <= s2_accepted_ff;
         count_ff        <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_match_count = count_ff;

endmodule
